/* hdl/bpsd_pkg.sv */
`timescale 1ns / 1ps
package bpsd_pkg;

  localparam int PalEntries = 256;
  localparam int PalAw = $clog2(PalEntries);
  localparam int MaxSide = 4096;
  localparam int SideW = $clog2(MaxSide) + 1;  // holds MaxSide itself
  localparam int RowW = SideW + 1;              // room for delta overshoot

  localparam logic [1:0] MODE_PAL = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  localparam logic [1:0] FMT_BGR24 = 2'd0;
  localparam logic [1:0] FMT_RLE8 = 2'd1;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [7:0] ESC_EOL = 8'h00;
  localparam logic [7:0] ESC_EOB = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } in_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] color;
    logic [7:0]  span_length;
    logic        last;
    logic        image_done;
  } out_t;

  function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* hdl/bpsd_ram.sv */
`timescale 1ns / 1ps
module bpsd_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/bmp_pixel_stream_decoder_core.sv */
`timescale 1ns / 1ps
// One item is taken at a time; in_stall is high until its work is done.
// Palette writes, restarts and bytes that emit nothing leave the core idle.
// A byte that emits spans goes to ST_RUN (in RLE8 through ST_READ first for the
// palette RAM read), which emits the spans in turn and holds while out_stall holds one.
// A finishing escape goes through ST_MARK; an RLE8 delta past the row end, through ST_DIV.
// Synchronous reset clears control state, sets config defaults; palette RAM is not cleared.
module bmp_pixel_stream_decoder_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bpsd_pkg::in_t     in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output bpsd_pkg::out_t    out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data
);
  import bpsd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_RUN = 3'd2;
  localparam logic [2:0] ST_MARK = 3'd3;
  localparam logic [2:0] ST_DIV = 3'd4;

  logic [1:0]  pixel_format;
  logic [12:0] image_width, image_height;
  logic [SideW-1:0] w_eff, h_eff;

  logic [2:0]  state, state_next;
  logic [SideW-1:0] col, col_next;
  logic [RowW-1:0]  row, row_next;
  logic [3:0]  phase, phase_next;
  logic [7:0]  pending, pending_next;
  logic [15:0] gather, gather_next;
  logic [1:0]  pad, pad_next;
  logic        finished, finished_next;
  logic [7:0]  cnt, cnt_next;
  logic [15:0] run_color, run_color_next;
  logic        run_bgr, run_bgr_next;
  logic        out_load;
  out_t        out_next;

  logic        accept, pal_we;
  logic [15:0] pal_rdata;

  // span logic
  logic             wrap;
  logic [SideW-1:0] col0, room, col_after;
  logic [RowW-1:0]  row0;
  logic [7:0]       len;
  logic             fin_span, slot_free;
  logic [3:0]       ph;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign pal_we = accept && (in_item.mode == MODE_PAL);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    w_eff = image_width[SideW-1:0];
    if (image_width < 13'd16) w_eff = SideW'(16);
    else if (image_width > 13'(MaxSide)) w_eff = SideW'(MaxSide);
    h_eff = image_height[SideW-1:0];
    if (image_height < 13'd1) h_eff = SideW'(1);
    else if (image_height > 13'(MaxSide)) h_eff = SideW'(MaxSide);
  end

  bpsd_ram #(.Width(16), .Depth(PalEntries)) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_item.palette_index[PalAw-1:0]),
    .wdata (to565(in_item.palette_color[23:16], in_item.palette_color[15:8],
                  in_item.palette_color[7:0])),
    .raddr (in_item.data_byte[PalAw-1:0]),
    .rdata (pal_rdata)
  );

  always_comb begin
    wrap = col >= w_eff;
    col0 = wrap ? '0 : col;
    row0 = wrap ? row + RowW'(1) : row;
    room = w_eff - col0;
    len = (room < SideW'(cnt)) ? room[7:0] : cnt;
    col_after = col0 + SideW'(len);
    fin_span = (col_after >= w_eff) && ((row0 + RowW'(1)) >= RowW'(h_eff));
  end

  always_comb begin
    state_next = state;
    col_next = col;
    row_next = row;
    phase_next = phase;
    pending_next = pending;
    gather_next = gather;
    pad_next = pad;
    finished_next = finished;
    cnt_next = cnt;
    run_color_next = run_color;
    run_bgr_next = run_bgr;
    out_load = 1'b0;
    out_next = '0;
    ph = phase;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.mode == MODE_START) begin
            col_next = '0;
            row_next = '0;
            phase_next = '0;
            pending_next = '0;
            gather_next = '0;
            pad_next = '0;
            finished_next = 1'b0;
          end else if (in_item.mode == MODE_DATA && !finished) begin
            run_bgr_next = 1'b0;
            cnt_next = 8'd1;
            if (pixel_format == FMT_BGR24) begin
              if (ph > 4'd2) ph = '0;
              phase_next = ph;
              if (pad != 2'd0) begin
                pad_next = pad - 2'd1;
              end else if (ph == 4'd0) begin
                gather_next = {8'h00, in_item.data_byte};
                phase_next = 4'd1;
              end else if (ph == 4'd1) begin
                gather_next = {gather[15:8] | in_item.data_byte, gather[7:0]};
                phase_next = 4'd2;
              end else begin
                run_color_next = to565(in_item.data_byte, gather[15:8], gather[7:0]);
                run_bgr_next = 1'b1;
                phase_next = 4'd0;
                state_next = ST_RUN;
              end
            end else if (pixel_format == FMT_RLE8) begin
              if (ph > 4'd6) ph = '0;
              phase_next = ph;
              priority case (ph)
                4'd0: begin
                  if (in_item.data_byte != 8'd0) begin
                    pending_next = in_item.data_byte;
                    phase_next = 4'd1;
                  end else begin
                    phase_next = 4'd2;
                  end
                end
                4'd1: begin
                  cnt_next = pending;
                  phase_next = 4'd0;
                  // an empty run emits nothing
                  if (pending != 8'd0) state_next = ST_READ;
                end
                4'd2: begin
                  phase_next = 4'd0;
                  if (in_item.data_byte == ESC_EOL) begin
                    col_next = '0;
                    row_next = row + RowW'(1);
                    if ((row + RowW'(1)) >= RowW'(h_eff)) begin
                      finished_next = 1'b1;
                      state_next = ST_MARK;
                    end
                  end else if (in_item.data_byte == ESC_EOB) begin
                    finished_next = 1'b1;
                    state_next = ST_MARK;
                  end else if (in_item.data_byte == ESC_DELTA) begin
                    phase_next = 4'd3;
                  end else begin
                    pending_next = in_item.data_byte;
                    gather_next = {15'd0, in_item.data_byte[0]};
                    phase_next = 4'd5;
                  end
                end
                4'd3: begin
                  col_next = col + SideW'(in_item.data_byte);
                  phase_next = 4'd4;
                  if ((col + SideW'(in_item.data_byte)) > w_eff) state_next = ST_DIV;
                end
                4'd4: begin
                  row_next = row + RowW'(in_item.data_byte);
                  phase_next = 4'd0;
                  if ((row + RowW'(in_item.data_byte)) >= RowW'(h_eff)) begin
                    finished_next = 1'b1;
                    state_next = ST_MARK;
                  end
                end
                4'd5: begin
                  state_next = ST_READ;
                  if (pending > 8'd1) begin
                    pending_next = pending - 8'd1;
                  end else begin
                    pending_next = '0;
                    phase_next = gather[0] ? 4'd6 : 4'd0;
                  end
                end
                default: phase_next = 4'd0;
              endcase
            end else begin
              if (ph > 4'd1) ph = '0;
              if (ph == 4'd0) begin
                gather_next = {8'h00, in_item.data_byte};
                phase_next = 4'd1;
              end else begin
                run_color_next = {in_item.data_byte, gather[7:0]};
                phase_next = 4'd0;
                state_next = ST_RUN;
              end
            end
          end
        end
      end
      ST_READ: begin
        run_color_next = pal_rdata;
        state_next = ST_RUN;
      end
      ST_DIV: begin
        // divide the overrun column by the width, one row a cycle
        if (col >= w_eff) begin
          col_next = col - w_eff;
          row_next = row + RowW'(1);
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_next.last = 1'b1;
          out_next.image_done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin  // ST_RUN: one span a cycle while the output slot is free
        if (slot_free) begin
          out_load = 1'b1;
          col_next = col0;
          row_next = row0;
          if (row0 >= RowW'(h_eff)) begin
            finished_next = 1'b1;
            out_next.last = 1'b1;
            out_next.image_done = 1'b1;
            state_next = ST_IDLE;
          end else begin
            out_next.pixel_x = col0[11:0];
            out_next.pixel_y = 12'(RowW'(h_eff) - RowW'(1) - row0);
            out_next.color = run_color;
            out_next.span_length = len;
            col_next = col_after;
            cnt_next = cnt - len;
            finished_next = fin_span;
            out_next.image_done = fin_span;
            if ((cnt == len) || fin_span) begin
              out_next.last = 1'b1;
              state_next = ST_IDLE;
              if (run_bgr && !fin_span && col_after >= w_eff) pad_next = w_eff[1:0];
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col <= '0;
      row <= '0;
      phase <= '0;
      pending <= '0;
      gather <= '0;
      pad <= '0;
      finished <= 1'b0;
      cnt <= '0;
      run_color <= '0;
      run_bgr <= 1'b0;
      out_valid <= 1'b0;
      pixel_format <= 2'd0;
      image_width <= 13'd320;
      image_height <= 13'd240;
    end else begin
      state <= state_next;
      col <= col_next;
      row <= row_next;
      phase <= phase_next;
      pending <= pending_next;
      gather <= gather_next;
      pad <= pad_next;
      finished <= finished_next;
      cnt <= cnt_next;
      run_color <= run_color_next;
      run_bgr <= run_bgr_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FORMAT: pixel_format <= cfg_data[1:0];
          REG_WIDTH:  image_width <= cfg_data;
          REG_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_item <= out_next;
  end

  a_run_not_finished: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !finished) else $error("run while image finished");
  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt != 8'd0)) else $error("empty run");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.image_done |-> out_item.last) else $error("done without last");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall)) else $error("result overwritten");
endmodule
